### rtl/dha_pkg.sv
// ----------------------------------------------------------------------------
// dha_pkg
// Types and fixed constants shared by the dihedral angle pipeline.
// ----------------------------------------------------------------------------
package dha_pkg;

	localparam int CW_IN  = 32;   // input coordinate width
	localparam int BW     = 33;   // bond vector component
	localparam int MW     = 32;   // bond component magnitude
	localparam int LW     = 5;    // leading-one index of a magnitude
	localparam int RED_LO = 13;   // reduced vectors lie in [2^13, 2^14)
	localparam int RMW    = 14;   // reduced magnitude
	localparam int RW     = 15;   // reduced component, signed
	localparam int PW     = 30;   // cross product terms and normals
	localparam int SQW    = 28;   // square of a reduced component
	localparam int SSW    = 30;   // |b2|^2
	localparam int RADW   = 40;   // sqrt radicand
	localparam int ROOTW  = 20;   // sqrt root
	localparam int SQRT_PER    = 4;
	localparam int SQRT_STAGES = ROOTW / SQRT_PER;
	localparam int XPW    = 59;   // n1[k]*n2[k]
	localparam int XSW    = 61;   // n1.n2
	localparam int TPW    = 44;   // n1[k]*b3[k]
	localparam int TSW    = 46;   // n1.b3
	localparam int TMW    = 45;   // |n1.b3|
	localparam int TLO    = 23;   // low split of |t|
	localparam int AW     = 60;   // CORDIC input magnitudes before scaling
	localparam int ALW    = 6;    // leading-one index of AW
	localparam int CNORM  = 29;   // scaled larger side lies in [2^29, 2^30)
	localparam int CIW    = 30;
	localparam int CXW    = 34;   // CORDIC x, y
	localparam int ZW     = 33;   // CORDIC angle accumulator
	localparam int CORDIC_STEPS  = 30;
	localparam int CORDIC_PER    = 3;
	localparam int CORDIC_STAGES = CORDIC_STEPS / CORDIC_PER;

	localparam logic [31:0] PI_Q30      = 32'd3373259426;
	localparam logic [31:0] HALF_PI_Q30 = 32'd1686629713;

	localparam logic [31:0] ATAN_Q30 [CORDIC_STEPS] = '{
		32'h3243F6A8, 32'h1DAC6705, 32'h0FADBAFC, 32'h07F56EA6, 32'h03FEAB76,
		32'h01FFD55B, 32'h00FFFAAA, 32'h007FFF55, 32'h003FFFEA, 32'h001FFFFD,
		32'h000FFFFF, 32'h0007FFFF, 32'h0003FFFF, 32'h0001FFFF, 32'h0000FFFF,
		32'h00007FFF, 32'h00003FFF, 32'h00001FFF, 32'h00000FFF, 32'h000007FF,
		32'h000003FF, 32'h000001FF, 32'h000000FF, 32'h0000007F, 32'h0000003F,
		32'h0000001F, 32'h0000000F, 32'h00000008, 32'h00000004, 32'h00000002
	};

	typedef struct packed {
		logic signed [CW_IN-1:0] p1_x;
		logic signed [CW_IN-1:0] p1_y;
		logic signed [CW_IN-1:0] p1_z;
		logic signed [CW_IN-1:0] p2_x;
		logic signed [CW_IN-1:0] p2_y;
		logic signed [CW_IN-1:0] p2_z;
		logic signed [CW_IN-1:0] p3_x;
		logic signed [CW_IN-1:0] p3_y;
		logic signed [CW_IN-1:0] p3_z;
		logic signed [CW_IN-1:0] p4_x;
		logic signed [CW_IN-1:0] p4_y;
		logic signed [CW_IN-1:0] p4_z;
	} points_t;

	typedef struct packed {
		logic signed [15:0] torsion;
		logic               degenerate;
	} angle_t;

	typedef struct packed {
		logic degen;
		logic x_neg;
		logic t_neg;
	} flags_t;

endpackage

### rtl/dha_stream_if.sv
// ----------------------------------------------------------------------------
// dha_stream_if
// Valid/ready channel carrying one payload per transaction.
// ----------------------------------------------------------------------------
interface dha_stream_if #(parameter type T = logic) ();
	logic valid;
	logic ready;
	T     data;

	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

### rtl/dha_front.sv
// ----------------------------------------------------------------------------
// dha_front
// Bond vectors and per-vector power-of-two reduction (stages 1 to 4).
// ----------------------------------------------------------------------------
module dha_front (
	input  logic clk,
	input  logic arst_n,
	input  logic en,
	input  logic v_in,
	input  dha_pkg::points_t pts,
	output logic v_out,
	output logic signed [dha_pkg::RW-1:0] c [3][3]
);
	import dha_pkg::*;

	logic signed [CW_IN-1:0] pt [4][3];
	logic signed [BW-1:0]    b_s1 [3][3];
	logic [MW-1:0]           m_s2 [3][3];
	logic                    neg_s2 [3][3];
	logic [MW-1:0]           top_s2 [3];
	logic [MW-1:0]           m_s3 [3][3];
	logic                    neg_s3 [3][3];
	logic [LW-1:0]           lead_s3 [3];
	logic signed [RW-1:0]    c_s4 [3][3];
	logic                    v_s1, v_s2, v_s3, v_s4;

	always_comb begin
		pt[0][0] = pts.p1_x; pt[0][1] = pts.p1_y; pt[0][2] = pts.p1_z;
		pt[1][0] = pts.p2_x; pt[1][1] = pts.p2_y; pt[1][2] = pts.p2_z;
		pt[2][0] = pts.p3_x; pt[2][1] = pts.p3_y; pt[2][2] = pts.p3_z;
		pt[3][0] = pts.p4_x; pt[3][1] = pts.p4_y; pt[3][2] = pts.p4_z;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else if (en) begin
			v_s1 <= v_in;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				for (int k = 0; k < 3; k++) begin
					b_s1[i][k] <= {pt[i+1][k][CW_IN-1], pt[i+1][k]}
						- {pt[i][k][CW_IN-1], pt[i][k]};
				end
			end
		end
	end

	// stage 2: magnitudes and the largest of each vector
	always_ff @(posedge clk) begin
		logic [MW-1:0] mg;
		logic [MW-1:0] tp;
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				tp = '0;
				for (int k = 0; k < 3; k++) begin
					mg = b_s1[i][k][BW-1] ? MW'(-b_s1[i][k]) : MW'(b_s1[i][k]);
					m_s2[i][k]   <= mg;
					neg_s2[i][k] <= b_s1[i][k][BW-1];
					if (mg > tp)
						tp = mg;
				end
				top_s2[i] <= tp;
			end
		end
	end

	// stage 3: leading-one position of the largest magnitude
	always_ff @(posedge clk) begin
		logic [LW-1:0] ld;
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				ld = '0;
				for (int j = 0; j < MW; j++) begin
					if (top_s2[i][j])
						ld = LW'(j);
				end
				lead_s3[i] <= ld;
				for (int k = 0; k < 3; k++) begin
					m_s3[i][k]   <= m_s2[i][k];
					neg_s3[i][k] <= neg_s2[i][k];
				end
			end
		end
	end

	// stage 4: truncating right shift or exact left shift, sign restored
	always_ff @(posedge clk) begin
		logic [MW-1:0] sh;
		logic [RW-1:0] r;
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				for (int k = 0; k < 3; k++) begin
					if (lead_s3[i] >= LW'(RED_LO))
						sh = m_s3[i][k] >> (lead_s3[i] - LW'(RED_LO));
					else
						sh = m_s3[i][k] << (LW'(RED_LO) - lead_s3[i]);
					r = {1'b0, sh[RMW-1:0]};
					c_s4[i][k] <= neg_s3[i][k] ? -$signed(r) : $signed(r);
				end
			end
		end
	end

	assign v_out = v_s4;
	assign c     = c_s4;
endmodule

### rtl/dha_sqrt.sv
// ----------------------------------------------------------------------------
// dha_sqrt
// Pipelined integer square root, a few result bits per stage.
// ----------------------------------------------------------------------------
module dha_sqrt (
	input  logic clk,
	input  logic en,
	input  logic [dha_pkg::RADW-1:0] rad,
	output logic [dha_pkg::ROOTW-1:0] root
);
	import dha_pkg::*;

	localparam int REMW = ROOTW + 3;

	logic [RADW-1:0]  rad_s  [SQRT_STAGES+1];
	logic [REMW-1:0]  rem_s  [SQRT_STAGES+1];
	logic [ROOTW-1:0] root_s [SQRT_STAGES+1];

	assign rad_s[0]  = rad;
	assign rem_s[0]  = '0;
	assign root_s[0] = '0;

	for (genvar g = 0; g < SQRT_STAGES; g++) begin : g_stage
		logic [RADW-1:0]  rd;
		logic [REMW-1:0]  rm;
		logic [ROOTW-1:0] rt;
		logic [REMW-1:0]  trial;

		always_comb begin
			rd = rad_s[g];
			rm = rem_s[g];
			rt = root_s[g];
			trial = '0;
			for (int j = 0; j < SQRT_PER; j++) begin
				rm    = {rm[REMW-3:0], rd[RADW-1 -: 2]};
				rd    = {rd[RADW-3:0], 2'b00};
				trial = {1'b0, rt, 2'b01};
				if (rm >= trial) begin
					rm = rm - trial;
					rt = {rt[ROOTW-2:0], 1'b1};
				end else begin
					rt = {rt[ROOTW-2:0], 1'b0};
				end
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rad_s[g+1]  <= rd;
				rem_s[g+1]  <= rm;
				root_s[g+1] <= rt;
			end
		end
	end

	assign root = root_s[SQRT_STAGES];
endmodule

### rtl/dha_geom.sv
// ----------------------------------------------------------------------------
// dha_geom
// Normals, dot and triple products, |b2| and the opposite side (stages 5-13).
// ----------------------------------------------------------------------------
module dha_geom (
	input  logic clk,
	input  logic arst_n,
	input  logic en,
	input  logic v_in,
	input  logic signed [dha_pkg::RW-1:0] c [3][3],
	output logic v_out,
	output logic [dha_pkg::AW-1:0] ax,
	output logic [dha_pkg::AW-1:0] ay,
	output dha_pkg::flags_t flags
);
	import dha_pkg::*;

	logic signed [PW-1:0]  pa_s5 [2][3];
	logic signed [PW-1:0]  pb_s5 [2][3];
	logic [SQW-1:0]        sq_s5 [3];
	logic signed [RW-1:0]  c2_s5 [3];
	logic signed [PW-1:0]  n_s6 [2][3];
	logic [SSW-1:0]        ss_s6;
	logic signed [RW-1:0]  c2_s6 [3];
	logic                  dg_s6, dg_s7, dg_s8, dg_s9, dg_s10, dg_s11;
	logic signed [XPW-1:0] xp_s7 [3];
	logic signed [TPW-1:0] tp_s7 [3];
	logic signed [XSW-1:0] x_s8, x_s9, x_s10, x_s11;
	logic signed [TSW-1:0] t_s8, t_s9, t_s10, t_s11;
	logic [AW-1:0]         xm_s12, ax_s13, ay_s13;
	logic [ROOTW+TLO-1:0]  pl_s12;
	logic [ROOTW+TMW-TLO-1:0] ph_s12;
	flags_t                fl_s12, fl_s13;
	logic [ROOTW-1:0]      root;
	logic [TMW-1:0]        tm;
	logic [63:0]           prod;
	logic [PW-1:0]         nz1, nz2;
	logic                  v_s5, v_s6, v_s7, v_s8, v_s9, v_s10, v_s11, v_s12, v_s13;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s5  <= 1'b0; v_s6  <= 1'b0; v_s7  <= 1'b0;
			v_s8  <= 1'b0; v_s9  <= 1'b0; v_s10 <= 1'b0;
			v_s11 <= 1'b0; v_s12 <= 1'b0; v_s13 <= 1'b0;
		end else if (en) begin
			v_s5  <= v_in;  v_s6  <= v_s5;  v_s7  <= v_s6;
			v_s8  <= v_s7;  v_s9  <= v_s8;  v_s10 <= v_s9;
			v_s11 <= v_s10; v_s12 <= v_s11; v_s13 <= v_s12;
		end
	end

	// stage 5: cross product terms, n1 = c0 x c1, n2 = c1 x c2, and squares of c1
	always_ff @(posedge clk) begin
		logic signed [PW-1:0] sqp;
		if (en) begin
			for (int j = 0; j < 2; j++) begin
				for (int k = 0; k < 3; k++) begin
					pa_s5[j][k] <= c[j][(k+1)%3] * c[j+1][(k+2)%3];
					pb_s5[j][k] <= c[j][(k+2)%3] * c[j+1][(k+1)%3];
				end
			end
			for (int k = 0; k < 3; k++) begin
				sqp = c[1][k] * c[1][k];
				sq_s5[k] <= sqp[SQW-1:0];
				c2_s5[k] <= c[2][k];
			end
		end
	end

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			nz1[k] = (pa_s5[0][k] != pb_s5[0][k]);
			nz2[k] = (pb_s5[1][k] != pa_s5[1][k]);
		end
		nz1[PW-1:3] = '0;
		nz2[PW-1:3] = '0;
	end

	// stage 6: normals and |b2|^2
	always_ff @(posedge clk) begin
		if (en) begin
			for (int j = 0; j < 2; j++)
				for (int k = 0; k < 3; k++)
					n_s6[j][k] <= pa_s5[j][k] - pb_s5[j][k];
			ss_s6 <= SSW'(sq_s5[0]) + SSW'(sq_s5[1]) + SSW'(sq_s5[2]);
			dg_s6 <= (nz1 == '0) || (nz2 == '0);
			c2_s6 <= c2_s5;
		end
	end

	dha_sqrt u_sqrt (
		.clk  (clk),
		.en   (en),
		.rad  ({2'b00, ss_s6, 8'h00}),
		.root (root)
	);

	// stage 7: dot product terms
	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < 3; k++) begin
				xp_s7[k] <= n_s6[0][k] * n_s6[1][k];
				tp_s7[k] <= n_s6[0][k] * c2_s6[k];
			end
			dg_s7 <= dg_s6;
		end
	end

	// stage 8: sums, then wait for the root
	always_ff @(posedge clk) begin
		if (en) begin
			x_s8   <= XSW'(xp_s7[0]) + XSW'(xp_s7[1]) + XSW'(xp_s7[2]);
			t_s8   <= TSW'(tp_s7[0]) + TSW'(tp_s7[1]) + TSW'(tp_s7[2]);
			dg_s8  <= dg_s7;
			x_s9   <= x_s8;  t_s9  <= t_s8;  dg_s9  <= dg_s8;
			x_s10  <= x_s9;  t_s10 <= t_s9;  dg_s10 <= dg_s9;
			x_s11  <= x_s10; t_s11 <= t_s10; dg_s11 <= dg_s10;
		end
	end

	assign tm = t_s11[TSW-1] ? TMW'(-t_s11) : TMW'(t_s11);

	// stage 12: s * |t| split in two partial products
	always_ff @(posedge clk) begin
		if (en) begin
			xm_s12 <= x_s11[XSW-1] ? AW'(-x_s11) : AW'(x_s11);
			pl_s12 <= root * tm[TLO-1:0];
			ph_s12 <= root * tm[TMW-1:TLO];
			fl_s12 <= '{degen: dg_s11, x_neg: x_s11[XSW-1], t_neg: t_s11[TSW-1]};
		end
	end

	assign prod = (64'(ph_s12) << TLO) + 64'(pl_s12);

	// stage 13: y = s * |t| / 16
	always_ff @(posedge clk) begin
		if (en) begin
			ax_s13 <= xm_s12;
			ay_s13 <= prod[63:4];
			fl_s13 <= fl_s12;
		end
	end

	assign v_out = v_s13;
	assign ax    = ax_s13;
	assign ay    = ay_s13;
	assign flags = fl_s13;
endmodule

### rtl/dha_cordic.sv
// ----------------------------------------------------------------------------
// dha_cordic
// Scaling, vectoring CORDIC and angle finish (stages 14 to 27).
// ----------------------------------------------------------------------------
module dha_cordic #(
	parameter int ANGLE_FRAC_BITS = 13
) (
	input  logic clk,
	input  logic arst_n,
	input  logic en,
	input  logic v_in,
	input  logic [dha_pkg::AW-1:0] ax,
	input  logic [dha_pkg::AW-1:0] ay,
	input  dha_pkg::flags_t flags,
	output logic v_out,
	output dha_pkg::angle_t res
);
	import dha_pkg::*;

	localparam int SH = 30 - ANGLE_FRAC_BITS;

	logic [AW-1:0]  ax_s14, ay_s14, top_s14, ax_s15, ay_s15;
	logic [ALW-1:0] lead_s15;
	flags_t         fl_s14, fl_s15;
	logic           v_s14, v_s15;
	logic [ALW-1:0] ld;
	logic [AW-1:0]  sx, sy;

	logic signed [CXW-1:0] cx_s [CORDIC_STAGES+1];
	logic signed [CXW-1:0] cy_s [CORDIC_STAGES+1];
	logic signed [ZW-1:0]  cz_s [CORDIC_STAGES+1];
	flags_t                cf_s [CORDIC_STAGES+1];
	logic                  cv_s [CORDIC_STAGES+1];

	angle_t        res_q;
	logic          v_q;
	logic [31:0]   zc, ang;
	logic [33:0]   rsum;
	logic [15:0]   q;
	angle_t        res_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s14 <= 1'b0;
			v_s15 <= 1'b0;
			for (int g = 0; g <= CORDIC_STAGES; g++)
				cv_s[g] <= 1'b0;
			v_q <= 1'b0;
		end else if (en) begin
			v_s14   <= v_in;
			v_s15   <= v_s14;
			cv_s[0] <= v_s15;
			for (int g = 0; g < CORDIC_STAGES; g++)
				cv_s[g+1] <= cv_s[g];
			v_q <= cv_s[CORDIC_STAGES];
		end
	end

	always_comb begin
		ld = '0;
		for (int j = 0; j < AW; j++) begin
			if (top_s14[j])
				ld = ALW'(j);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ax_s14   <= ax;
			ay_s14   <= ay;
			top_s14  <= (ax > ay) ? ax : ay;
			fl_s14   <= flags;
			ax_s15   <= ax_s14;
			ay_s15   <= ay_s14;
			lead_s15 <= ld;
			fl_s15   <= fl_s14;
		end
	end

	// scale both sides together so that the larger lies in [2^29, 2^30)
	always_comb begin
		if (lead_s15 >= ALW'(CNORM)) begin
			sx = ax_s15 >> (lead_s15 - ALW'(CNORM));
			sy = ay_s15 >> (lead_s15 - ALW'(CNORM));
		end else begin
			sx = ax_s15 << (ALW'(CNORM) - lead_s15);
			sy = ay_s15 << (ALW'(CNORM) - lead_s15);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			cx_s[0] <= $signed(CXW'(sx[CIW-1:0]));
			cy_s[0] <= $signed(CXW'(sy[CIW-1:0]));
			cz_s[0] <= '0;
			cf_s[0] <= fl_s15;
		end
	end

	for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_rot
		logic signed [CXW-1:0] xn, yn, dx, dy;
		logic signed [ZW-1:0]  zn, at;

		always_comb begin
			xn = cx_s[g];
			yn = cy_s[g];
			zn = cz_s[g];
			dx = '0;
			dy = '0;
			at = '0;
			for (int j = 0; j < CORDIC_PER; j++) begin
				dx = yn >>> (g * CORDIC_PER + j);
				dy = xn >>> (g * CORDIC_PER + j);
				at = $signed(ZW'(ATAN_Q30[g * CORDIC_PER + j]));
				if (yn > 0) begin
					xn = xn + dx;
					yn = yn - dy;
					zn = zn + at;
				end else if (yn < 0) begin
					xn = xn - dx;
					yn = yn + dy;
					zn = zn - at;
				end
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				cx_s[g+1] <= xn;
				cy_s[g+1] <= yn;
				cz_s[g+1] <= zn;
				cf_s[g+1] <= cf_s[g];
			end
		end
	end

	// clamp to [0, pi/2], mirror for a negative cosine, round, apply sign
	always_comb begin
		if (cz_s[CORDIC_STAGES][ZW-1])
			zc = '0;
		else if (cz_s[CORDIC_STAGES] > $signed({1'b0, HALF_PI_Q30}))
			zc = HALF_PI_Q30;
		else
			zc = cz_s[CORDIC_STAGES][31:0];
		ang  = cf_s[CORDIC_STAGES].x_neg ? (PI_Q30 - zc) : zc;
		rsum = {2'b00, ang} + (34'(1) << (SH - 1));
		q    = 16'(rsum >> SH);
		if (cf_s[CORDIC_STAGES].degen) begin
			res_d.torsion    = '0;
			res_d.degenerate = 1'b1;
		end else begin
			res_d.torsion    = cf_s[CORDIC_STAGES].t_neg ? $signed(16'd0 - q) : $signed(q);
			res_d.degenerate = 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (en)
			res_q <= res_d;
	end

	assign v_out = v_q;
	assign res   = res_q;
endmodule

### rtl/dihedral_angle.sv
// ----------------------------------------------------------------------------
// dihedral_angle
// Signed torsion angle of four 3-D points, fully pipelined.
// ----------------------------------------------------------------------------
// Usage:
//   points : valid/ready sink, one transaction carries p1..p4 as signed Q16.16.
//   angle  : valid/ready source, one transaction per input transaction, in
//            order: torsion in radians (ANGLE_FRAC_BITS fraction bits) and the
//            degenerate flag, set with torsion 0 when a plane normal is zero.
// Throughput is one transaction per cycle while no result waits untaken. The
// stages from input transaction to result valid: bond reduction 4, normals,
// dot products and the pipelined square root of |b2| 9, scaling 3, ten CORDIC
// stages of three rotations each, and the output register.
// All stages share one advance enable, which is high whenever the output
// register is empty or being taken. When the receiver holds ready low with a
// result waiting, the whole pipe freezes and points.ready drops; nothing is
// lost or repeated. Reset clears every stage valid bit; no result is shown
// until a new input transaction has gone through.
// ----------------------------------------------------------------------------
module dihedral_angle #(
	parameter int ANGLE_FRAC_BITS = 13
) (
	input logic         clk,
	input logic         arst_n,
	dha_stream_if.sink   points,
	dha_stream_if.source angle
);
	import dha_pkg::*;

	logic                 en;
	logic                 v_f, v_g;
	logic signed [RW-1:0] c [3][3];
	logic [AW-1:0]        ax, ay;
	flags_t               fl;

	assign en           = !angle.valid || angle.ready;
	assign points.ready = en;

	dha_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.v_in   (points.valid),
		.pts    (points.data),
		.v_out  (v_f),
		.c      (c)
	);

	dha_geom u_geom (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.v_in   (v_f),
		.c      (c),
		.v_out  (v_g),
		.ax     (ax),
		.ay     (ay),
		.flags  (fl)
	);

	dha_cordic #(
		.ANGLE_FRAC_BITS (ANGLE_FRAC_BITS)
	) u_cordic (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.v_in   (v_g),
		.ax     (ax),
		.ay     (ay),
		.flags  (fl),
		.v_out  (angle.valid),
		.res    (angle.data)
	);
endmodule
